FILE: design/gdrm_pkg.sv
// Shared constants, control codes and handshake structs of the dose rate monitor.
// Used by the channel interfaces, the serial arithmetic units and the top level.
// Depends on nothing.
package gdrm_pkg;

    // Field and state widths.
    localparam int CNT_BITS   = 16;
    localparam int TIME_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int Q_BITS     = 48;
    localparam int DOSE_BITS  = 33;
    localparam int TOTAL_BITS = 64;
    localparam int COEF_BITS  = 16;
    localparam int DT_BITS    = 20;
    localparam int CONV_BITS  = 10;
    localparam int LIMIT_BITS = 16;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 20;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONV  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT = 2'd3;

    localparam logic [COEF_BITS-1:0]  COEF_RESET  = 16'd13107;
    localparam logic [DT_BITS-1:0]    DEAD_RESET  = 20'd190000;
    localparam logic [CONV_BITS-1:0]  CONV_RESET  = 10'd215;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd60;

    // Serial multiplier: MSB-first shift-add, one multiplier bit per cycle.
    localparam int MPL_BITS   = 16;
    localparam int MCAND_BITS = 50;
    localparam int ACC_BITS   = 66;

    // Serial divider: restoring, one quotient bit per cycle.
    localparam int DIVR_BITS = 30;
    localparam int DVD_BITS  = 48;

    // Arithmetic constants.
    localparam logic [DIVR_BITS-1:0] NS_PER_S   = 30'd1000000000;
    localparam logic [Q_BITS-1:0]    Q_MAX      = {Q_BITS{1'b1}};
    localparam logic [Q_BITS-1:0]    CPM_LIMIT  =
        Q_BITS'((((64'd1) << Q_BITS) - 64'd1) / 64'd60);
    // Twice 1000, so that half the conversion divisor becomes an integer init value.
    localparam logic [MPL_BITS-1:0]  DOSE_SCALE = 16'd2000;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_WATCH,
        S_LOSS,
        S_NUM,
        S_QDIV,
        S_CPM,
        S_DIFF,
        S_SMOOTH,
        S_DSTART,
        S_DMUL,
        S_DDIV,
        S_DONE
    } t_state;

    // Requests to the arithmetic units and their status.
    typedef struct packed {
        logic                         start;
        logic signed [ACC_BITS-1:0]   init;
        logic signed [MCAND_BITS-1:0] mcand;
        logic [MPL_BITS-1:0]          mplier;
    } t_mul_req;

    typedef struct packed {
        logic                 start;
        logic [DIVR_BITS-1:0] divisor;
        logic [DIVR_BITS-1:0] rem;
        logic [DVD_BITS-1:0]  dividend;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

FILE: design/gdrm_in_if.sv
// Input channel of the dose rate monitor: one counter snapshot per item.
// Depends on gdrm_pkg for the field widths.
interface gdrm_in_if;
    logic                           valid;
    logic                           ready;
    logic [gdrm_pkg::CNT_BITS-1:0]  count_snapshot;
    logic [gdrm_pkg::TIME_BITS-1:0] uptime_s;

    modport source (output valid, output count_snapshot, output uptime_s, input ready);
    modport sink   (input valid, input count_snapshot, input uptime_s, output ready);
endinterface

FILE: design/gdrm_out_if.sv
// Result channel of the dose rate monitor: one result item per input item.
// Depends on gdrm_pkg for the field widths.
interface gdrm_out_if;
    logic                            valid;
    logic                            ready;
    logic [gdrm_pkg::DOSE_BITS-1:0]  dose_rate_nsv_h;
    logic [gdrm_pkg::TOTAL_BITS-1:0] total_count;
    logic                            detector_fault;
    logic                            fault_raised;
    logic                            fault_cleared;
    logic                            rate_saturated;

    modport source (output valid, output dose_rate_nsv_h, output total_count,
                    output detector_fault, output fault_raised, output fault_cleared,
                    output rate_saturated, input ready);
    modport sink   (input valid, input dose_rate_nsv_h, input total_count,
                    input detector_fault, input fault_raised, input fault_cleared,
                    input rate_saturated, output ready);
endinterface

FILE: design/gdrm_mul.sv
// Bit-serial signed multiply-accumulate unit: acc = init * 2^MPL_BITS + mcand * mplier.
// One multiplier bit per cycle, MSB first. Depends on gdrm_pkg.
module gdrm_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gdrm_pkg::t_mul_req                     i_req,
    output gdrm_pkg::t_unit_sts                    o_sts,
    output logic signed [gdrm_pkg::ACC_BITS-1:0]   o_acc
);
    localparam int STEP_BITS = $clog2(gdrm_pkg::MPL_BITS + 1);

    logic [STEP_BITS-1:0]                   r_step, n_step;
    logic                                   r_done, n_done;
    logic signed [gdrm_pkg::ACC_BITS-1:0]   r_acc, n_acc;
    logic signed [gdrm_pkg::MCAND_BITS-1:0] r_mcand, n_mcand;
    logic [gdrm_pkg::MPL_BITS-1:0]          r_mpl, n_mpl;

    // Load on start, then shift the accumulator and add the multiplicand per set bit.
    always_comb begin
        n_step  = r_step;
        n_done  = 1'b0;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_mpl   = r_mpl;
        if (i_req.start) begin
            n_step  = STEP_BITS'(gdrm_pkg::MPL_BITS);
            n_acc   = i_req.init;
            n_mcand = i_req.mcand;
            n_mpl   = i_req.mplier;
        end else if (r_step != '0) begin
            n_acc  = (r_acc <<< 1) +
                     (r_mpl[gdrm_pkg::MPL_BITS-1] ? gdrm_pkg::ACC_BITS'(r_mcand) : '0);
            n_mpl  = r_mpl << 1;
            n_step = r_step - STEP_BITS'(1);
            n_done = (r_step == STEP_BITS'(1));
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
    end

    // Operands and accumulator.
    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_mpl   <= n_mpl;
    end

    assign o_sts.busy = (r_step != '0);
    assign o_sts.done = r_done;
    assign o_acc      = r_acc;
endmodule

FILE: design/gdrm_div.sv
// Bit-serial restoring divider: quotient of {rem, dividend} by divisor, one bit per cycle.
// The initial remainder must be below the divisor. Depends on gdrm_pkg.
module gdrm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gdrm_pkg::t_div_req               i_req,
    output gdrm_pkg::t_unit_sts              o_sts,
    output logic [gdrm_pkg::DVD_BITS-1:0]    o_quot
);
    localparam int STEP_BITS = $clog2(gdrm_pkg::DVD_BITS + 1);
    localparam int RB        = gdrm_pkg::DIVR_BITS;

    logic [STEP_BITS-1:0]          r_step, n_step;
    logic                          r_done, n_done;
    logic [RB-1:0]                 r_rem, n_rem;
    logic [RB-1:0]                 r_divr, n_divr;
    logic [gdrm_pkg::DVD_BITS-1:0] r_dvd, n_dvd;
    logic [RB:0]                   rem2;
    logic [RB+1:0]                 trial;

    // Shift one dividend bit into the remainder; quotient bits shift in behind it.
    always_comb begin
        rem2   = {r_rem, r_dvd[gdrm_pkg::DVD_BITS-1]};
        trial  = {1'b0, rem2} - {2'b00, r_divr};
        n_step = r_step;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_divr = r_divr;
        n_dvd  = r_dvd;
        if (i_req.start) begin
            n_step = STEP_BITS'(gdrm_pkg::DVD_BITS);
            n_rem  = i_req.rem;
            n_divr = i_req.divisor;
            n_dvd  = i_req.dividend;
        end else if (r_step != '0) begin
            if (!trial[RB+1]) begin
                n_rem = trial[RB-1:0];
                n_dvd = {r_dvd[gdrm_pkg::DVD_BITS-2:0], 1'b1};
            end else begin
                n_rem = rem2[RB-1:0];
                n_dvd = {r_dvd[gdrm_pkg::DVD_BITS-2:0], 1'b0};
            end
            n_step = r_step - STEP_BITS'(1);
            n_done = (r_step == STEP_BITS'(1));
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
    end

    // Remainder, divisor and dividend/quotient shift register.
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_divr <= n_divr;
        r_dvd  <= n_dvd;
    end

    assign o_sts.busy = (r_step != '0);
    assign o_sts.done = r_done;
    assign o_quot     = r_dvd;
endmodule

FILE: design/geiger_dose_rate_monitor_top.sv
// Top level of the Geiger dose rate monitor: watchdog, sequencer and result register.
// Depends on gdrm_pkg, gdrm_in_if, gdrm_out_if, gdrm_mul and gdrm_div.
//
// Usage: once per second the source offers a counter snapshot and the uptime on i_item.
// The block runs a silence watchdog, corrects the count delta for tube dead time,
// smooths counts per minute, converts to nSv/h and adds the corrected count to a 64-bit
// total. Each item gives exactly one result item on o_res.
// Throughput: one item at a time. The work is done by the shared bit-serial units: the
// 16-step multiplier runs up to four passes and the 48-step divider up to two per item.
// A saturated dead-time correction skips the first divider pass, and a fault tick skips
// every step before the dose conversion.
// i_item.ready is high whenever the sequencer is idle, also while a finished result still
// waits in the output register; a stalled receiver only holds the sequencer in its last
// step until the register frees up.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (coefficient, dead
// time, conversion factor, silence limit); write only while idle.
// Reset: synchronous, active low; it restores the register defaults, clears watchdog,
// smoothing and total state and empties the output register.
module geiger_dose_rate_monitor_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    gdrm_in_if.sink                               i_item,
    gdrm_out_if.source                            o_res,
    input  logic                                  i_cfg_we,
    input  logic [gdrm_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [gdrm_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    localparam int QB  = gdrm_pkg::Q_BITS;
    localparam int FB  = gdrm_pkg::FRAC_BITS;
    localparam int AB  = gdrm_pkg::ACC_BITS;
    localparam int MB  = gdrm_pkg::MCAND_BITS;
    localparam int CB  = gdrm_pkg::CNT_BITS;
    localparam int TB  = gdrm_pkg::TIME_BITS;
    localparam int RB  = gdrm_pkg::DIVR_BITS;
    localparam int DB  = gdrm_pkg::DVD_BITS;
    localparam int RND_BITS = QB - FB + 1;
    // Top bits of the dead-time numerator (cps * 1e9) that sit above the Q.48 range.
    localparam int NUM_HI_LSB  = DB - FB;
    localparam int NUM_HI_BITS = CB + RB - NUM_HI_LSB;

    // Configuration registers.
    logic [gdrm_pkg::COEF_BITS-1:0]  r_coef;
    logic [gdrm_pkg::DT_BITS-1:0]    r_dt;
    logic [gdrm_pkg::CONV_BITS-1:0]  r_conv;
    logic [gdrm_pkg::LIMIT_BITS-1:0] r_limit;

    // Sequencer and model state.
    gdrm_pkg::t_state r_state, n_state;
    logic [CB-1:0]                   r_seen, r_prev;
    logic [TB-1:0]                   r_last;
    logic                            r_fault;
    logic [QB-1:0]                   r_smooth;
    logic [gdrm_pkg::TOTAL_BITS-1:0] r_total;

    // Per-item working registers.
    logic [CB-1:0]       r_cnt_in, r_cps;
    logic [TB-1:0]       r_now;
    logic                r_raised, r_cleared, r_sat, r_lossov;
    logic [RB-1:0]       r_den;
    logic [QB-1:0]       r_corr, r_cpm;
    logic [RND_BITS-1:0] r_rnd;

    // Result register.
    logic                            r_ov;
    logic [gdrm_pkg::DOSE_BITS-1:0]  r_o_dose;
    logic [gdrm_pkg::TOTAL_BITS-1:0] r_o_total;
    logic                            r_o_fault, r_o_raised, r_o_cleared, r_o_sat;

    // Arithmetic units.
    gdrm_pkg::t_mul_req  mul_req;
    gdrm_pkg::t_div_req  div_req;
    gdrm_pkg::t_unit_sts mul_sts, div_sts;
    logic signed [AB-1:0] mul_acc;
    logic [DB-1:0]        div_quot;

    // Combinational helpers.
    logic                            in_fire, out_free, load_out;
    logic                            pulse, silent, ok;
    logic [CB-1:0]                   cps_w;
    logic [NUM_HI_BITS-1:0]          num_hi;
    logic                            quot_ovf;
    logic [QB+5:0]                   cpm60;
    logic signed [MB-1:0]            smooth_diff;
    logic signed [AB-1:0]            smooth_sum;
    logic [gdrm_pkg::CONV_BITS-1:0]  conv_eff;

    gdrm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_sts   (mul_sts),
        .o_acc   (mul_acc)
    );

    gdrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= gdrm_pkg::COEF_RESET;
            r_dt    <= gdrm_pkg::DEAD_RESET;
            r_conv  <= gdrm_pkg::CONV_RESET;
            r_limit <= gdrm_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gdrm_pkg::CFG_COEF:  r_coef  <= i_cfg_data[gdrm_pkg::COEF_BITS-1:0];
                gdrm_pkg::CFG_DEAD:  r_dt    <= i_cfg_data[gdrm_pkg::DT_BITS-1:0];
                gdrm_pkg::CFG_CONV:  r_conv  <= i_cfg_data[gdrm_pkg::CONV_BITS-1:0];
                gdrm_pkg::CFG_LIMIT: r_limit <= i_cfg_data[gdrm_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Watchdog, delta and arithmetic glue.
    always_comb begin
        in_fire  = i_item.valid && i_item.ready;
        out_free = !r_ov || o_res.ready;
        pulse    = (r_cnt_in != r_seen);
        silent   = ({1'b0, r_now} > ({1'b0, r_last} + (TB + 1)'(r_limit)));
        ok       = pulse || !silent;
        cps_w    = r_cnt_in - r_prev;
        num_hi   = mul_acc[CB+RB-1:NUM_HI_LSB];
        quot_ovf = ((RB)'(num_hi) >= r_den);
        cpm60    = ({6'b0, r_corr} << 6) - ({6'b0, r_corr} << 2);
        smooth_diff = $signed({{(MB-QB){1'b0}}, r_cpm}) -
                      $signed({{(MB-QB){1'b0}}, r_smooth});
        smooth_sum  = mul_acc + AB'(1 << (FB - 1));
        conv_eff = (r_conv == '0) ? gdrm_pkg::CONV_BITS'(1) : r_conv;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gdrm_pkg::S_IDLE:   if (in_fire) n_state = gdrm_pkg::S_WATCH;
            gdrm_pkg::S_WATCH:  n_state = ok ? gdrm_pkg::S_LOSS : gdrm_pkg::S_DSTART;
            gdrm_pkg::S_LOSS:   if (mul_sts.done) n_state = gdrm_pkg::S_NUM;
            gdrm_pkg::S_NUM: begin
                if (mul_sts.done) begin
                    n_state = (r_lossov || quot_ovf) ? gdrm_pkg::S_CPM : gdrm_pkg::S_QDIV;
                end
            end
            gdrm_pkg::S_QDIV:   if (div_sts.done) n_state = gdrm_pkg::S_CPM;
            gdrm_pkg::S_CPM:    n_state = gdrm_pkg::S_DIFF;
            gdrm_pkg::S_DIFF:   n_state = gdrm_pkg::S_SMOOTH;
            gdrm_pkg::S_SMOOTH: if (mul_sts.done) n_state = gdrm_pkg::S_DSTART;
            gdrm_pkg::S_DSTART: n_state = gdrm_pkg::S_DMUL;
            gdrm_pkg::S_DMUL:   if (mul_sts.done) n_state = gdrm_pkg::S_DDIV;
            gdrm_pkg::S_DDIV:   if (div_sts.done) n_state = gdrm_pkg::S_DONE;
            gdrm_pkg::S_DONE:   if (out_free) n_state = gdrm_pkg::S_IDLE;
            default:            n_state = gdrm_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and unit requests.
    always_comb begin
        i_item.ready = 1'b0;
        load_out     = 1'b0;
        mul_req      = '0;
        div_req      = '0;
        case (r_state)
            gdrm_pkg::S_IDLE: i_item.ready = 1'b1;
            gdrm_pkg::S_WATCH: begin
                // Loss term cps * dead time.
                if (ok) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = $signed({{(MB-gdrm_pkg::DT_BITS){1'b0}}, r_dt});
                    mul_req.mplier = cps_w;
                end
            end
            gdrm_pkg::S_LOSS: begin
                // Numerator cps * 1e9.
                if (mul_sts.done) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = $signed({{(MB-RB){1'b0}}, gdrm_pkg::NS_PER_S});
                    mul_req.mplier = r_cps;
                end
            end
            gdrm_pkg::S_NUM: begin
                // Fractional quotient cps * 1e9 * 2^FB / den.
                if (mul_sts.done && !r_lossov && !quot_ovf) begin
                    div_req.start    = 1'b1;
                    div_req.divisor  = r_den;
                    div_req.rem      = RB'(num_hi);
                    div_req.dividend = {mul_acc[NUM_HI_LSB-1:0], {FB{1'b0}}};
                end
            end
            gdrm_pkg::S_DIFF: begin
                // smoothed * 2^16 + coef * (cpm - smoothed).
                mul_req.start  = 1'b1;
                mul_req.init   = AB'($signed({1'b0, r_smooth}));
                mul_req.mcand  = smooth_diff;
                mul_req.mplier = r_coef;
            end
            gdrm_pkg::S_DSTART: begin
                // 2 * (smoothed * 1000 + conv * 2^(FB-1)).
                mul_req.start  = 1'b1;
                mul_req.init   = AB'($signed({1'b0, conv_eff}));
                mul_req.mcand  = $signed({{(MB-QB){1'b0}}, r_smooth});
                mul_req.mplier = gdrm_pkg::DOSE_SCALE;
            end
            gdrm_pkg::S_DMUL: begin
                if (mul_sts.done) begin
                    div_req.start    = 1'b1;
                    div_req.divisor  = RB'(conv_eff);
                    div_req.dividend = mul_acc[DB+FB:FB+1];
                end
            end
            gdrm_pkg::S_DONE: load_out = out_free;
            default: ;
        endcase
    end

    // Control state and model state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gdrm_pkg::S_IDLE;
            r_seen   <= '0;
            r_last   <= '0;
            r_prev   <= '0;
            r_fault  <= 1'b0;
            r_smooth <= '0;
            r_total  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == gdrm_pkg::S_WATCH) begin
                if (pulse) begin
                    r_seen <= r_cnt_in;
                    r_last <= r_now;
                end
                if (ok) begin
                    r_prev <= r_cnt_in;
                end
                r_fault <= !ok;
            end
            if (r_state == gdrm_pkg::S_DIFF) begin
                r_total <= r_total + gdrm_pkg::TOTAL_BITS'(r_rnd);
            end
            if (r_state == gdrm_pkg::S_SMOOTH && mul_sts.done) begin
                r_smooth <= smooth_sum[QB+FB-1:FB];
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Per-item working registers and result payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cnt_in <= i_item.count_snapshot;
            r_now    <= i_item.uptime_s;
        end
        case (r_state)
            gdrm_pkg::S_WATCH: begin
                r_cps     <= cps_w;
                r_sat     <= 1'b0;
                r_raised  <= !ok && !r_fault;
                r_cleared <= ok && r_fault;
            end
            gdrm_pkg::S_LOSS: begin
                if (mul_sts.done) begin
                    r_lossov <= (mul_acc[CB+gdrm_pkg::DT_BITS-1:0] >=
                                 (CB + gdrm_pkg::DT_BITS)'(gdrm_pkg::NS_PER_S));
                    r_den    <= gdrm_pkg::NS_PER_S - mul_acc[RB-1:0];
                end
            end
            gdrm_pkg::S_NUM: begin
                // A non-positive denominator or a quotient beyond Q.48 saturates.
                if (mul_sts.done) begin
                    if (r_lossov) begin
                        r_corr <= gdrm_pkg::Q_MAX;
                        r_sat  <= 1'b1;
                    end else if (quot_ovf) begin
                        r_corr <= gdrm_pkg::Q_MAX;
                    end
                end
            end
            gdrm_pkg::S_QDIV: if (div_sts.done) r_corr <= div_quot;
            gdrm_pkg::S_CPM: begin
                r_cpm <= (r_corr > gdrm_pkg::CPM_LIMIT) ? gdrm_pkg::Q_MAX : cpm60[QB-1:0];
                r_rnd <= RND_BITS'(({1'b0, r_corr} + (QB + 1)'(1 << (FB - 1))) >> FB);
            end
            default: ;
        endcase
        if (load_out) begin
            r_o_dose    <= (|div_quot[DB-1:gdrm_pkg::DOSE_BITS]) ?
                           {gdrm_pkg::DOSE_BITS{1'b1}} : div_quot[gdrm_pkg::DOSE_BITS-1:0];
            r_o_total   <= r_total;
            r_o_fault   <= r_fault;
            r_o_raised  <= r_raised;
            r_o_cleared <= r_cleared;
            r_o_sat     <= r_sat;
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.dose_rate_nsv_h = r_o_dose;
    assign o_res.total_count     = r_o_total;
    assign o_res.detector_fault  = r_o_fault;
    assign o_res.fault_raised    = r_o_raised;
    assign o_res.fault_cleared   = r_o_cleared;
    assign o_res.rate_saturated  = r_o_sat;

    // A unit is never restarted while it still iterates.
    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_sts.busy)
        else $error("multiplier restarted while busy");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider restarted while busy");

    // An accepted item always enters the watchdog step next.
    a_accept_watch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == gdrm_pkg::S_WATCH))
        else $error("accepted item did not reach the watchdog");

    // A new fault skips processing and goes straight to the dose conversion.
    a_fault_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fault) |-> (r_state == gdrm_pkg::S_DSTART))
        else $error("fault tick did not skip processing");

    // A raised fault is reported together with the fault state, never with the cleared or saturated flag.
    a_raised_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_raised) |-> (r_o_fault && !r_o_cleared && !r_o_sat))
        else $error("inconsistent fault flags in result item");
endmodule
